>>> rtl/core/tet_pkg.sv
`default_nettype none

package tet_pkg;

   // Position counter width; positions go out as 16-bit fields
   localparam int POS_BITS = 16;

   // Queue between the classifying front and the emitting back
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = $clog2(Q_DEPTH);
   localparam int Q_CW    = $clog2(Q_DEPTH + 1);

   localparam logic [2:0] DOT_RUN_LEN = 3'd3;
   localparam logic [2:0] DOT_RUN_MAX = 3'd7;

   localparam logic [15:0] CH_DOT  = 16'h002E;
   localparam logic [15:0] CH_STAR = 16'h002A;

   // Token kinds
   localparam logic [4:0] KIND_BANG     = 5'd0;
   localparam logic [4:0] KIND_LPAREN   = 5'd1;
   localparam logic [4:0] KIND_RPAREN   = 5'd2;
   localparam logic [4:0] KIND_COMMA    = 5'd3;
   localparam logic [4:0] KIND_STAR     = 5'd4;
   localparam logic [4:0] KIND_COLON    = 5'd5;
   localparam logic [4:0] KIND_LT       = 5'd6;
   localparam logic [4:0] KIND_EQ       = 5'd7;
   localparam logic [4:0] KIND_GT       = 5'd8;
   localparam logic [4:0] KIND_QUEST    = 5'd9;
   localparam logic [4:0] KIND_LBRACK   = 5'd10;
   localparam logic [4:0] KIND_RBRACK   = 5'd11;
   localparam logic [4:0] KIND_LBRACE   = 5'd12;
   localparam logic [4:0] KIND_PIPE     = 5'd13;
   localparam logic [4:0] KIND_RBRACE   = 5'd14;
   localparam logic [4:0] KIND_ELLIPSIS = 5'd15;
   localparam logic [4:0] KIND_NAME     = 5'd16;
   localparam logic [4:0] KIND_INVALID  = 5'd17;
   localparam logic [4:0] KIND_END      = 5'd18;

   typedef logic [POS_BITS-1:0] pos_type;

   // Kind of the token still being collected
   typedef enum logic [2:0] {
      PEND_NONE = 3'b001,
      PEND_DOTS = 3'b010,
      PEND_NAME = 3'b100
   } pend_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic        dot_err;
   } tok_type;

   // One queue entry: the tokens that one input item caused
   typedef struct packed {
      tok_type tok0;
      tok_type tok1;
      logic    two;
   } entry_type;

   function automatic logic is_line_term(input logic [15:0] c);
      return c == 16'h000A || c == 16'h000D || c == 16'h2028 || c == 16'h2029;
   endfunction

   function automatic logic is_space(input logic [15:0] c);
      return is_line_term(c) || c == 16'h0009 || c == 16'h000B || c == 16'h000C ||
             c == 16'h0020 || c == 16'h00A0 || c == 16'h1680 ||
             (c >= 16'h2000 && c <= 16'h200A) || c == 16'h202F ||
             c == 16'h205F || c == 16'h3000 || c == 16'hFEFF;
   endfunction

   function automatic logic is_id_start(input logic [15:0] c);
      logic ascii_id;
      ascii_id = (c >= 16'h0041 && c <= 16'h005A) || (c >= 16'h0061 && c <= 16'h007A) ||
                 c == 16'h0024 || c == 16'h005F;
      return (c >= 16'h0080) ? !is_space(c) : ascii_id;
   endfunction

   function automatic logic is_name_part(input logic [15:0] c);
      return is_id_start(c) || (c >= 16'h0030 && c <= 16'h0039) || c == CH_DOT;
   endfunction

   // Punctuator lookup: {hit, kind}
   function automatic logic [5:0] punct_lookup(input logic [15:0] c);
      logic [5:0] r;
      unique case (c)
         16'h0021: r = {1'b1, KIND_BANG};
         16'h0028: r = {1'b1, KIND_LPAREN};
         16'h0029: r = {1'b1, KIND_RPAREN};
         16'h002C: r = {1'b1, KIND_COMMA};
         16'h002A: r = {1'b1, KIND_STAR};
         16'h003A: r = {1'b1, KIND_COLON};
         16'h003C: r = {1'b1, KIND_LT};
         16'h003D: r = {1'b1, KIND_EQ};
         16'h003E: r = {1'b1, KIND_GT};
         16'h003F: r = {1'b1, KIND_QUEST};
         16'h005B: r = {1'b1, KIND_LBRACK};
         16'h005D: r = {1'b1, KIND_RBRACK};
         16'h007B: r = {1'b1, KIND_LBRACE};
         16'h007C: r = {1'b1, KIND_PIPE};
         16'h007D: r = {1'b1, KIND_RBRACE};
         default:  r = {1'b0, KIND_INVALID};
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/tet_front.sv
`default_nettype none

module tet_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic               csr_write_data,
   input  wire logic               accept,
   input  wire logic               func,
   input  wire logic [15:0]        ch,
   output tet_pkg::entry_type      push_data,
   output logic                    push
);

   logic              doc_ff;
   tet_pkg::pend_type pend_ff, pend_in;
   logic [2:0]        cnt_ff, cnt_in;
   tet_pkg::pos_type  start_ff, start_in;
   tet_pkg::pos_type  pos_ff, pos_in;
   logic              nl_ff, nl_in;

   tet_pkg::pos_type  nx;
   logic [5:0]        punct;
   logic              cont;
   logic              flush_v;
   logic              own_v;
   tet_pkg::tok_type  flush_tok;
   tet_pkg::tok_type  own_tok;

   // Saturating next position and punctuator decode
   assign nx    = (pos_ff == '1) ? pos_ff : pos_ff + tet_pkg::pos_type'(1);
   assign punct = tet_pkg::punct_lookup(ch);

   // Token for whatever is pending, ending at the current position
   always_comb begin
      flush_tok.start_pos = 16'(start_ff);
      flush_tok.end_pos   = 16'(pos_ff);
      flush_tok.dot_err   = 1'b0;
      flush_tok.kind      = tet_pkg::KIND_NAME;
      if (pend_ff == tet_pkg::PEND_DOTS) begin
         if (cnt_ff == tet_pkg::DOT_RUN_LEN) begin
            flush_tok.kind = tet_pkg::KIND_ELLIPSIS;
         end else begin
            flush_tok.kind    = tet_pkg::KIND_INVALID;
            flush_tok.dot_err = 1'b1;
         end
      end
   end

   // Classify the item and update the lexer state
   always_comb begin
      pend_in  = pend_ff;
      cnt_in   = cnt_ff;
      start_in = start_ff;
      pos_in   = pos_ff;
      nl_in    = nl_ff;
      flush_v  = 1'b0;
      own_v    = 1'b0;
      own_tok.kind      = tet_pkg::KIND_INVALID;
      own_tok.start_pos = 16'(pos_ff);
      own_tok.end_pos   = 16'(nx);
      own_tok.dot_err   = 1'b0;
      cont = ((pend_ff == tet_pkg::PEND_DOTS) && ch == tet_pkg::CH_DOT) ||
             ((pend_ff == tet_pkg::PEND_NAME) && tet_pkg::is_name_part(ch));
      if (accept) begin
         if (func) begin
            flush_v         = pend_ff != tet_pkg::PEND_NONE;
            own_v           = 1'b1;
            own_tok.kind    = tet_pkg::KIND_END;
            own_tok.end_pos = 16'(pos_ff);
            pend_in  = tet_pkg::PEND_NONE;
            cnt_in   = 3'd0;
            start_in = '0;
            pos_in   = '0;
            nl_in    = 1'b0;
         end else if (cont) begin
            pos_in = nx;
            if (pend_ff == tet_pkg::PEND_DOTS && cnt_ff != tet_pkg::DOT_RUN_MAX) begin
               cnt_in = cnt_ff + 3'd1;
            end
         end else begin
            pos_in  = nx;
            flush_v = pend_ff != tet_pkg::PEND_NONE;
            pend_in = tet_pkg::PEND_NONE;
            cnt_in  = 3'd0;
            if (tet_pkg::is_space(ch)) begin
               if (tet_pkg::is_line_term(ch)) begin
                  nl_in = 1'b1;
               end
            end else if (doc_ff && nl_ff && ch == tet_pkg::CH_STAR) begin
               // drop the leading star of a doc-comment line
               nl_in = 1'b0;
            end else begin
               nl_in = 1'b0;
               if (punct[5]) begin
                  own_v        = 1'b1;
                  own_tok.kind = punct[4:0];
               end else if (ch == tet_pkg::CH_DOT) begin
                  pend_in  = tet_pkg::PEND_DOTS;
                  cnt_in   = 3'd1;
                  start_in = pos_ff;
               end else if (tet_pkg::is_id_start(ch)) begin
                  pend_in  = tet_pkg::PEND_NAME;
                  start_in = pos_ff;
               end else begin
                  own_v = 1'b1;
               end
            end
         end
      end
   end

   // Pack the tokens of this item, flushed token first
   always_comb begin
      push           = flush_v || own_v;
      push_data.two  = flush_v && own_v;
      push_data.tok0 = flush_v ? flush_tok : own_tok;
      push_data.tok1 = own_tok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         doc_ff   <= 1'b0;
         pend_ff  <= tet_pkg::PEND_NONE;
         cnt_ff   <= 3'd0;
         start_ff <= '0;
         pos_ff   <= '0;
         nl_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            doc_ff <= csr_write_data;
         end
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         start_ff <= start_in;
         pos_ff   <= pos_in;
         nl_ff    <= nl_in;
      end
   end

   // End of text always produces at least the end token
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (accept && func) |-> push)
      else $error("end of text produced no token");

endmodule

`default_nettype wire

>>> rtl/core/tet_queue.sv
`default_nettype none

module tet_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire tet_pkg::entry_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output tet_pkg::entry_type      head_data
);

   tet_pkg::entry_type             mem [tet_pkg::Q_DEPTH];
   logic [tet_pkg::Q_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [tet_pkg::Q_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [tet_pkg::Q_CW-1:0]       count_ff, count_in;

   assign full       = count_ff == tet_pkg::Q_CW'(tet_pkg::Q_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tet_pkg::Q_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + tet_pkg::Q_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + tet_pkg::Q_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - tet_pkg::Q_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tet_pkg::Q_CW'(tet_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/tet_back.sv
`default_nettype none

module tet_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               head_valid,
   input  wire tet_pkg::entry_type head_data,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [4:0]              rsp_token_kind,
   output logic [15:0]             rsp_token_start,
   output logic [15:0]             rsp_token_end,
   output logic                    rsp_dot_error,
   output logic                    rsp_last_of_run
);

   logic             valid_ff, valid_in;
   logic             sel_ff, sel_in;
   tet_pkg::tok_type tok_ff, tok_in;
   logic             last_ff, last_in;
   logic             free;
   logic             load;

   // Output register is free when empty or being transferred
   assign free = !valid_ff || !rsp_stall;
   assign load = free && head_valid;
   assign pop  = load && (sel_ff || !head_data.two);

   // Step through the tokens of the head entry, one per transfer
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (free) begin
         valid_in = head_valid;
      end
      if (load) begin
         tok_in  = sel_ff ? head_data.tok1 : head_data.tok0;
         last_in = sel_ff || !head_data.two;
         sel_in  = !sel_ff && head_data.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_token_kind  = tok_ff.kind;
   assign rsp_token_start = tok_ff.start_pos;
   assign rsp_token_end   = tok_ff.end_pos;
   assign rsp_dot_error   = tok_ff.dot_err;
   assign rsp_last_of_run = last_ff;

   // The second token of a pair follows right after the first
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !last_ff && !rsp_stall) |=> valid_ff)
      else $error("second token of a pair missing");

endmodule

`default_nettype wire

>>> rtl/core/type_expression_tokenizer.sv
// Type-expression tokenizer: one UTF-16 character (req_func = 0) or an
// end-of-text mark (req_func = 1) per req_ transfer; tokens come out on the
// rsp_ channel with kind, start and end positions, dot-run error flag and a
// last_of_run flag on the final token caused by each input item.
// csr_write_enable/csr_write_data set doc-comment mode (drop a leading '*'
// after a line break); write it only while the block is idle.
// A token passes through the queue, written at the accepting edge, and then
// the output register, loaded from the queue head, before it shows on rsp_.
// Throughput: one input item per cycle while req_stall is low, one token per
// cycle out while rsp_stall is low; an item that yields two tokens (a flushed
// token plus its own) holds the output for both, absorbed by a 4-entry
// queue between the front classifier and the output stage. Items that yield
// no token (whitespace, characters extending a name or dot run) never enter
// the queue. req_stall rises only when that queue is full; rsp_stall holds the
// output register, and once the queue fills, req_stall holds the input side.
// Reset (synchronous, active high) clears the lexer state, position counter,
// queue and doc-comment mode; the block takes items in the first cycle after.
`default_nettype none

module type_expression_tokenizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [15:0] req_ch,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_end,
   output logic             rsp_dot_error,
   output logic             rsp_last_of_run
);

   logic               accept;
   logic               push;
   tet_pkg::entry_type push_data;
   logic               full;
   logic               pop;
   logic               head_valid;
   tet_pkg::entry_type head_data;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   tet_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .func             (req_func),
      .ch               (req_ch),
      .push_data        (push_data),
      .push             (push)
   );

   tet_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   tet_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_data       (head_data),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_end   (rsp_token_end),
      .rsp_dot_error   (rsp_dot_error),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

>>> tb/tb_type_expression_tokenizer.sv
`default_nettype none

module tb_type_expression_tokenizer;
   import tet_pkg::*;

   localparam logic FUNC_CHAR = 1'b0;
   localparam logic FUNC_END  = 1'b1;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int HOLD_CYCLES  = 80;
   localparam int HOLD_AFTER   = 450;
   localparam int CALM_FROM    = 300;
   localparam int CALM_TO      = 450;
   localparam int IDLE_PERCENT = 15;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic        func;
      logic [15:0] ch;
   } lex_item_type;

   typedef struct packed {
      logic [4:0]  kind;
      logic [15:0] start_at;
      logic [15:0] end_at;
      logic        dot_err;
      logic        last;
   } token_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_func = FUNC_CHAR;
   logic [15:0] req_ch = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [4:0]  rsp_token_kind;
   logic [15:0] rsp_token_start;
   logic [15:0] rsp_token_end;
   logic        rsp_dot_error;
   logic        rsp_last_of_run;

   type_expression_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_ch           (req_ch),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_end    (rsp_token_end),
      .rsp_dot_error    (rsp_dot_error),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   lex_item_type  char_queue [$];
   token_rec_type token_expect [$];
   lex_item_type  next_item;
   int         accepted_count = 0;
   int         fail_count = 0;
   int         cycle_count = 0;
   int         hold_count = 0;
   logic       receiver_hold = 1'b0;
   logic       hold_done = 1'b0;

   // Lexer state as the block should hold it
   logic       doc_mode_model = 1'b0;
   pend_type   pend_model = PEND_NONE;
   logic [2:0] dots_seen = '0;
   pos_type    tok_start = '0;
   pos_type    next_pos = '0;
   logic       nl_in_gap = 1'b0;

   wire calm = accepted_count >= CALM_FROM && accepted_count < CALM_TO;

   logic [15:0] punct_text [15] = '{
      16'h0021, 16'h0028, 16'h0029, 16'h002C, 16'h002A, 16'h003A, 16'h003C, 16'h003D,
      16'h003E, 16'h003F, 16'h005B, 16'h005D, 16'h007B, 16'h007C, 16'h007D
   };

   // Line terminators sit at the tail, from index 13 on
   logic [15:0] blank_chars [17] = '{
      16'h0009, 16'h000B, 16'h000C, 16'h0020, 16'h00A0, 16'h1680, 16'h2000, 16'h2005,
      16'h200A, 16'h202F, 16'h205F, 16'h3000, 16'hFEFF, 16'h000A, 16'h000D, 16'h2028,
      16'h2029
   };

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic is_break(input logic [15:0] c);
      return c == 16'h000A || c == 16'h000D || c == 16'h2028 || c == 16'h2029;
   endfunction

   function automatic logic is_blank(input logic [15:0] c);
      if (is_break(c)) return 1'b1;
      case (c)
         16'h0009, 16'h000B, 16'h000C, 16'h0020, 16'h00A0, 16'h1680, 16'h202F,
         16'h205F, 16'h3000, 16'hFEFF: return 1'b1;
         default: return c >= 16'h2000 && c <= 16'h200A;
      endcase
   endfunction

   function automatic logic starts_name(input logic [15:0] c);
      if (c >= 16'h0080) return !is_blank(c);
      return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "$" || c == "_";
   endfunction

   function automatic logic continues_name(input logic [15:0] c);
      return starts_name(c) || (c >= "0" && c <= "9") || c == CH_DOT;
   endfunction

   // Kind of a one-character punctuator, or -1
   function automatic int punct_code(input logic [15:0] c);
      case (c)
         16'h0021: return KIND_BANG;
         16'h0028: return KIND_LPAREN;
         16'h0029: return KIND_RPAREN;
         16'h002C: return KIND_COMMA;
         16'h002A: return KIND_STAR;
         16'h003A: return KIND_COLON;
         16'h003C: return KIND_LT;
         16'h003D: return KIND_EQ;
         16'h003E: return KIND_GT;
         16'h003F: return KIND_QUEST;
         16'h005B: return KIND_LBRACK;
         16'h005D: return KIND_RBRACK;
         16'h007B: return KIND_LBRACE;
         16'h007C: return KIND_PIPE;
         16'h007D: return KIND_RBRACE;
         default:  return -1;
      endcase
   endfunction

   function automatic token_rec_type make_token(input logic [4:0] kind, input logic [15:0] s,
                                                input logic [15:0] e, input logic err,
                                                input logic last);
      token_rec_type t;
      t.kind     = kind;
      t.start_at = s;
      t.end_at   = e;
      t.dot_err  = err;
      t.last     = last;
      return t;
   endfunction

   // Close the token being collected, if any, and clear the run state
   function automatic logic take_pending(input pos_type end_at, output token_rec_type tok);
      logic hit;
      hit = 1'b1;
      tok = '0;
      case (pend_model)
         PEND_DOTS: begin
            if (dots_seen == DOT_RUN_LEN)
               tok = make_token(KIND_ELLIPSIS, 16'(tok_start), 16'(end_at), 1'b0, 1'b0);
            else
               tok = make_token(KIND_INVALID, 16'(tok_start), 16'(end_at), 1'b1, 1'b0);
         end
         PEND_NAME: tok = make_token(KIND_NAME, 16'(tok_start), 16'(end_at), 1'b0, 1'b0);
         default: hit = 1'b0;
      endcase
      pend_model = PEND_NONE;
      dots_seen  = '0;
      return hit;
   endfunction

   // Advance the lexer by one transfer and queue the tokens it completes
   function automatic void predict_tokens(input logic func, input logic [15:0] c);
      token_rec_type found [$];
      token_rec_type tok;
      pos_type    here;
      pos_type    after;
      int         pk;
      logic       absorbed;
      here     = next_pos;
      after    = (next_pos == '1) ? next_pos : next_pos + 1'b1;
      absorbed = 1'b0;
      if (func == FUNC_END) begin
         if (take_pending(here, tok)) found.push_back(tok);
         found.push_back(make_token(KIND_END, 16'(here), 16'(here), 1'b0, 1'b0));
         tok_start = '0;
         next_pos  = '0;
         nl_in_gap = 1'b0;
      end else begin
         next_pos = after;
         // extend a pending run or close it
         if (pend_model == PEND_DOTS) begin
            if (c == CH_DOT) begin
               if (dots_seen != DOT_RUN_MAX) dots_seen = dots_seen + 1'b1;
               absorbed = 1'b1;
            end else if (take_pending(here, tok)) begin
               found.push_back(tok);
            end
         end else if (pend_model == PEND_NAME) begin
            if (continues_name(c)) absorbed = 1'b1;
            else if (take_pending(here, tok)) found.push_back(tok);
         end
         if (!absorbed) begin
            if (is_blank(c)) begin
               if (is_break(c)) nl_in_gap = 1'b1;
            end else if (doc_mode_model && nl_in_gap && c == CH_STAR) begin
               nl_in_gap = 1'b0;
            end else begin
               nl_in_gap = 1'b0;
               pk = punct_code(c);
               if (pk >= 0) begin
                  found.push_back(make_token(5'(pk), 16'(here), 16'(after), 1'b0, 1'b0));
               end else if (c == CH_DOT) begin
                  pend_model = PEND_DOTS;
                  dots_seen  = 3'd1;
                  tok_start  = here;
               end else if (starts_name(c)) begin
                  pend_model = PEND_NAME;
                  tok_start  = here;
               end else begin
                  found.push_back(make_token(KIND_INVALID, 16'(here), 16'(after), 1'b0, 1'b0));
               end
            end
         end
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) token_expect.push_back(found[i]);
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_char(input logic [15:0] c);
      lex_item_type it;
      it.func = FUNC_CHAR;
      it.ch   = c;
      char_queue.push_back(it);
   endfunction

   function automatic void push_end(input logic [15:0] c);
      lex_item_type it;
      it.func = FUNC_END;
      it.ch   = c;
      char_queue.push_back(it);
   endfunction

   function automatic void push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char({8'h00, s[i]});
   endfunction

   function automatic logic [15:0] name_char();
      case ($urandom_range(5))
         0: return 16'(16'h0041 + $urandom_range(25));
         1: return 16'(16'h0061 + $urandom_range(25));
         2: return 16'h0024;
         3: return 16'h005F;
         4: return 16'(16'h0080 + $urandom_range(16'hFF7F));
         // non-blank neighbors of the blank ranges
         default: begin
            case ($urandom_range(3))
               0: return 16'h1FFF;
               1: return 16'h200B;
               2: return 16'h0080;
               default: return 16'hFFFE;
            endcase
         end
      endcase
   endfunction

   function automatic void push_random_text(input int count, input logic with_ends);
      int pushed;
      int pick;
      int run;
      pushed = 0;
      while (pushed < count) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            push_char(punct_text[$urandom_range(14)]);
         end else if (pick < 33) begin
            // dot runs, mostly the three-dot form
            case ($urandom_range(9))
               5: run = 1;
               6: run = 2;
               7: run = 4;
               8: run = 5;
               9: run = 8;
               default: run = 3;
            endcase
            repeat (run) push_char(CH_DOT);
            pushed += run - 1;
         end else if (pick < 53) begin
            push_char(name_char());
         end else if (pick < 60) begin
            push_char(16'(16'h0030 + $urandom_range(9)));
         end else if (pick < 72) begin
            push_char(blank_chars[$urandom_range(16)]);
         end else if (pick < 78) begin
            // line break followed by a leading star
            push_char(blank_chars[13 + $urandom_range(3)]);
            push_char(CH_STAR);
            pushed++;
         end else if (pick < 82) begin
            push_char(CH_STAR);
         end else if (pick < 88) begin
            push_char(16'($urandom_range(127)));
         end else if (pick < 95 || !with_ends) begin
            push_char(16'($urandom_range(16'hFFFF)));
         end else begin
            push_end(16'($urandom_range(16'hFFFF)));
         end
         pushed++;
      end
   endfunction

   // Wait until every item is taken and every token has come out
   task automatic settle();
      @(negedge clock);
      while (char_queue.size() != 0 || req_valid || token_expect.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_doc_mode(input logic value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      doc_mode_model = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: star at start, ellipsis, names, blanks, invalid and short runs
      push_text("*...!a1._");
      push_char(16'h00A0);
      push_text("#..(");
      push_char(16'hFFFF);
      push_char(16'h0000);
      push_end(16'hFFFF);
      settle();

      // directed: leading stars after line breaks, long dot run cut by end of text
      write_doc_mode(1'b1);
      push_char(16'h000A);
      push_text("**");
      push_char(16'h2028);
      push_text(" *....");
      push_end(16'h0000);
      settle();

      // random text under both modes
      for (int ph = 0; ph < 4; ph++) begin
         write_doc_mode(ph[0]);
         push_random_text(200, 1'b1);
         settle();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && token_expect.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         req_func       <= FUNC_CHAR;
         req_ch         <= '0;
         accepted_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_tokens(req_func, req_ch);
            accepted_count <= accepted_count + 1;
         end
         // hold a stalled item, otherwise offer the next one or idle
         if (!req_valid || !req_stall) begin
            if (char_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
               next_item = char_queue.pop_front();
               req_valid <= 1'b1;
               req_func  <= next_item.func;
               req_ch    <= next_item.ch;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_token();
      token_rec_type got;
      token_rec_type want;
      got = make_token(rsp_token_kind, rsp_token_start, rsp_token_end, rsp_dot_error,
                       rsp_last_of_run);
      if (token_expect.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected token: kind %0d start %0d end %0d err %0b last %0b",
                     got.kind, got.start_at, got.end_at, got.dot_err, got.last);
      end else begin
         want = token_expect.pop_front();
         if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"token mismatch: expected kind %0d start %0d end %0d err %0b ",
                         "last %0b, got kind %0d start %0d end %0d err %0b last %0b"},
                        want.kind, want.start_at, want.end_at, want.dot_err, want.last,
                        got.kind, got.start_at, got.end_at, got.dot_err, got.last);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_token();
         rsp_stall <= receiver_hold || (!calm && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   // Hold the result side off once for a long stretch so the input backs up
   always @(posedge clock) begin
      if (reset) begin
         receiver_hold <= 1'b0;
         hold_count    <= 0;
         hold_done     <= 1'b0;
      end else if (receiver_hold) begin
         hold_count <= hold_count + 1;
         if (hold_count == HOLD_CYCLES - 1) receiver_hold <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         receiver_hold <= 1'b1;
         hold_done     <= 1'b1;
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule

`default_nettype wire
